// ===== hw/rtl/chbd_pkg.sv =====
// ============================================================================
// chbd_pkg
// Shared types and constants for the chunked HTTP body decoder.
// ============================================================================
`default_nettype none

package chbd_pkg;

   // Default width of the chunk size counter.
   localparam int SIZE_BITS_DEFAULT = 32;

   // Default depth of the queue between the classifier and the executor.
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Control characters that end a size line.
   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   // Error codes reported on the result channel.
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_EMPTY    = 2'd1;
   localparam logic [1:0] ERR_OVERFLOW = 2'd2;

   // Decoder phases.
   typedef enum logic [2:0] {
      PH_LEAD   = 3'd0,
      PH_DIGITS = 3'd1,
      PH_REST   = 3'd2,
      PH_DATA   = 3'd3,
      PH_SKIP   = 3'd4,
      PH_DONE   = 3'd5,
      PH_ERROR  = 3'd6
   } phase_type;

   // One classified input byte as it travels through the queue.
   typedef struct packed {
      logic [7:0] body_byte;
      logic       start_of_body;
      logic       hex_ok;
      logic [3:0] hex_val;
      logic       blank;
      logic       is_cr;
      logic       is_lf;
   } item_type;

endpackage

`default_nettype wire

// ===== hw/rtl/http_chunked_body_decoder_top.sv =====
// ============================================================================
// http_chunked_body_decoder_top
// Chunked HTTP/1.1 body decoder, one body byte per transaction.
//
// The request channel (req_valid, req_stall) carries one raw body byte and a
// start-of-body flag; a flagged byte clears the decoder and opens a size line.
// The response channel (rsp_valid, rsp_stall) returns exactly one transaction
// per request: the payload byte with its valid flag, the body-complete flag
// and the sticky error code.
// A classifier accepts and decodes each byte, a queue of QUEUE_DEPTH entries
// holds the classified bytes, and an executor runs the chunk state machine
// and loads the response register. An accepted byte is written into a queue
// slot and then popped into the response register, and while the receiver
// does not stall, one transaction per cycle is sustained, as the executor
// updates its state with every pop.
// When the receiver stalls, the response register holds its transaction, the
// queue fills, and req_stall rises once the queue is full.
// Reset empties the queue and the response register and puts the decoder at
// the start of a size line with no error.
// ============================================================================
`default_nettype none

module http_chunked_body_decoder_top #(
   parameter int SIZE_BITS   = chbd_pkg::SIZE_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = chbd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_body_byte,
   input  wire logic       req_start_of_body,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_payload_valid,
   output logic [7:0]      rsp_payload_byte,
   output logic            rsp_body_complete,
   output logic [1:0]      rsp_error_code
);

   // Classified bytes move from the front into the queue.
   chbd_pkg::item_type push_item;
   chbd_pkg::item_type pop_item;
   logic               push;
   logic               queue_full;
   logic               pop;
   logic               pop_valid;

   chbd_front u_front (
      .req_valid         (req_valid),
      .req_body_byte     (req_body_byte),
      .req_start_of_body (req_start_of_body),
      .req_stall         (req_stall),
      .queue_full        (queue_full),
      .push              (push),
      .item              (push_item)
   );

   chbd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_item  (pop_item)
   );

   // The executor pops whenever its response register is free or draining.
   chbd_back #(
      .SIZE_BITS (SIZE_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .item_valid        (pop_valid),
      .item              (pop_item),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_payload_valid (rsp_payload_valid),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_body_complete (rsp_body_complete),
      .rsp_error_code    (rsp_error_code)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/chbd_front.sv =====
// ============================================================================
// chbd_front
// Accepts request transactions and classifies each byte for the executor.
// ============================================================================
`default_nettype none

module chbd_front (
   input  wire logic              req_valid,
   input  wire logic [7:0]        req_body_byte,
   input  wire logic              req_start_of_body,
   output logic                   req_stall,
   input  wire logic              queue_full,
   output logic                   push,
   output chbd_pkg::item_type     item
);

   logic [7:0] c;

   assign c         = req_body_byte;
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      item               = '0;
      item.body_byte     = c;
      item.start_of_body = req_start_of_body;
      item.is_cr         = (c == chbd_pkg::CHAR_CR);
      item.is_lf         = (c == chbd_pkg::CHAR_LF);
      // Blanks are space, tab, LF, VT, FF and CR.
      item.blank         = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
      if (c >= 8'h30 && c <= 8'h39) begin
         item.hex_ok  = 1'b1;
         item.hex_val = c[3:0];
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         // Letters a-f and A-F share their low three bits: 1 maps to 10.
         item.hex_ok  = 1'b1;
         item.hex_val = 4'(c[2:0] + 3'd1) + 4'd8;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/chbd_queue.sv =====
// ============================================================================
// chbd_queue
// Small register queue that decouples the classifier from the executor.
// ============================================================================
`default_nettype none

module chbd_queue #(
   parameter int DEPTH = chbd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire chbd_pkg::item_type push_item,
   output logic                    full,
   input  wire logic               pop,
   output logic                    pop_valid,
   output chbd_pkg::item_type      pop_item
);

   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   chbd_pkg::item_type slot_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full      = (count_ff == CNT_BITS'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/chbd_back.sv =====
// ============================================================================
// chbd_back
// Executes the chunk decoding state machine and holds the response register.
// ============================================================================
`default_nettype none

module chbd_back #(
   parameter int SIZE_BITS = chbd_pkg::SIZE_BITS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               item_valid,
   input  wire chbd_pkg::item_type item,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_payload_valid,
   output logic [7:0]              rsp_payload_byte,
   output logic                    rsp_body_complete,
   output logic [1:0]              rsp_error_code
);

   chbd_pkg::phase_type  phase_ff, phase_in;
   logic [SIZE_BITS-1:0] left_ff, left_in;
   logic                 nonempty_ff, nonempty_in;
   logic                 saw_cr_ff, saw_cr_in;
   logic [1:0]           skip_ff, skip_in;
   logic [1:0]           err_ff, err_in;
   logic                 rsp_valid_ff;
   logic                 payload_valid_ff, payload_valid_in;
   logic [7:0]           payload_byte_ff, payload_byte_in;
   logic                 complete_ff, complete_in;
   logic [1:0]           error_ff, error_in;
   chbd_pkg::phase_type  ph;

   assign pop = item_valid && (!rsp_valid_ff || !rsp_stall);

   // Next state. A start-of-body byte clears the decoder before it is used.
   always_comb begin
      chbd_pkg::phase_type  cur;
      logic [SIZE_BITS-1:0] left;
      logic                 ne;
      logic                 cr;
      logic [1:0]           sk;
      logic [1:0]           er;
      cur  = phase_ff;
      left = left_ff;
      ne   = nonempty_ff;
      cr   = saw_cr_ff;
      sk   = skip_ff;
      er   = err_ff;
      if (item.start_of_body) begin
         cur  = chbd_pkg::PH_LEAD;
         left = '0;
         ne   = 1'b0;
         cr   = 1'b0;
         sk   = 2'd0;
         er   = chbd_pkg::ERR_NONE;
      end
      ph          = cur;
      phase_in    = cur;
      left_in     = left;
      nonempty_in = ne;
      saw_cr_in   = cr;
      skip_in     = sk;
      err_in      = er;
      unique case (cur)
         chbd_pkg::PH_LEAD, chbd_pkg::PH_DIGITS, chbd_pkg::PH_REST: begin
            if (cr && item.is_lf) begin
               saw_cr_in = 1'b0;
               if (!ne) begin
                  phase_in = chbd_pkg::PH_ERROR;
                  err_in   = chbd_pkg::ERR_EMPTY;
               end else if (left == '0) begin
                  phase_in = chbd_pkg::PH_DONE;
               end else begin
                  phase_in = chbd_pkg::PH_DATA;
               end
            end else begin
               // A pending CR that is not followed by LF is line content.
               if (cr) begin
                  nonempty_in = 1'b1;
                  if (cur == chbd_pkg::PH_DIGITS) begin
                     phase_in = chbd_pkg::PH_REST;
                  end
               end
               if (item.is_cr) begin
                  saw_cr_in = 1'b1;
               end else begin
                  saw_cr_in   = 1'b0;
                  nonempty_in = 1'b1;
                  if (phase_in != chbd_pkg::PH_REST) begin
                     if (item.hex_ok) begin
                        if (left[SIZE_BITS-1 -: 4] != 4'd0) begin
                           phase_in = chbd_pkg::PH_ERROR;
                           err_in   = chbd_pkg::ERR_OVERFLOW;
                        end else begin
                           left_in  = {left[SIZE_BITS-5:0], item.hex_val};
                           phase_in = chbd_pkg::PH_DIGITS;
                        end
                     end else if (!(phase_in == chbd_pkg::PH_LEAD && item.blank)) begin
                        phase_in = chbd_pkg::PH_REST;
                     end
                  end
               end
            end
         end
         chbd_pkg::PH_DATA: begin
            left_in = left - SIZE_BITS'(1);
            if (left == SIZE_BITS'(1)) begin
               phase_in = chbd_pkg::PH_SKIP;
               skip_in  = 2'd2;
            end
         end
         chbd_pkg::PH_SKIP: begin
            skip_in = sk - 2'd1;
            if (sk == 2'd1) begin
               phase_in    = chbd_pkg::PH_LEAD;
               left_in     = '0;
               nonempty_in = 1'b0;
               saw_cr_in   = 1'b0;
            end
         end
         default: begin
            // Done and error phases ignore every byte.
         end
      endcase
   end

   // Response fields.
   always_comb begin
      payload_valid_in = (ph == chbd_pkg::PH_DATA);
      payload_byte_in  = payload_valid_in ? item.body_byte : 8'd0;
      complete_in      = (phase_in == chbd_pkg::PH_DONE);
      error_in         = err_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= chbd_pkg::PH_LEAD;
         left_ff      <= '0;
         nonempty_ff  <= 1'b0;
         saw_cr_ff    <= 1'b0;
         skip_ff      <= 2'd0;
         err_ff       <= chbd_pkg::ERR_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff    <= phase_in;
            left_ff     <= left_in;
            nonempty_ff <= nonempty_in;
            saw_cr_ff   <= saw_cr_in;
            skip_ff     <= skip_in;
            err_ff      <= err_in;
         end
         if (pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         payload_valid_ff <= payload_valid_in;
         payload_byte_ff  <= payload_byte_in;
         complete_ff      <= complete_in;
         error_ff         <= error_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_payload_valid = payload_valid_ff;
   assign rsp_payload_byte  = payload_byte_ff;
   assign rsp_body_complete = complete_ff;
   assign rsp_error_code    = error_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/chbd_checker.sv =====
// ============================================================================
// chbd_checker
// Port-level checks on the response channel of the chunked body decoder.
// ============================================================================
`default_nettype none

module chbd_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic       rsp_payload_valid,
   input wire logic [7:0] rsp_payload_byte,
   input wire logic       rsp_body_complete,
   input wire logic [1:0] rsp_error_code
);

   // A stalled response transaction holds all of its fields.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload_valid)
         && $stable(rsp_payload_byte) && $stable(rsp_body_complete)
         && $stable(rsp_error_code))
      else $error("stalled response changed");

   // Payload only flows while the body is neither complete nor in error.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload_valid |-> !rsp_body_complete
         && rsp_error_code == chbd_pkg::ERR_NONE)
      else $error("payload after completion or error");

   // A non-payload response carries a zero byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload_valid |-> rsp_payload_byte == 8'd0)
      else $error("nonzero byte without payload");

   // Completion and error exclude each other, and code three is never used.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_error_code != 2'd3
         && !(rsp_body_complete && rsp_error_code != chbd_pkg::ERR_NONE))
      else $error("bad completion or error code");

endmodule

bind http_chunked_body_decoder_top chbd_checker u_chbd_checker (.*);

`default_nettype wire

// ===== tb/http_chunked_body_decoder_checker.sv =====
// ============================================================================
// http_chunked_body_decoder_checker
// Watches both channels of the chunked body decoder, keeps its own model of
// the chunk state machine, and compares every response transaction with the
// prediction made when the matching request transaction was accepted.
// ============================================================================

module http_chunked_body_decoder_checker #(
   parameter int SIZE_BITS = chbd_pkg::SIZE_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_body_byte,
   input  logic       req_start_of_body,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic       rsp_payload_valid,
   input  logic [7:0] rsp_payload_byte,
   input  logic       rsp_body_complete,
   input  logic [1:0] rsp_error_code,
   output int         fail_count,
   output int         pending_rsps,
   output int         checked_rsps,
   output int         payload_rsps,
   output int         complete_rsps,
   output int         error_rsps
);

   typedef struct packed {
      logic       payload_valid;
      logic [7:0] payload_byte;
      logic       body_complete;
      logic [1:0] error_code;
   } decoded_rsp_type;

   // Decoder state as this side sees it.
   chbd_pkg::phase_type  dec_phase;
   logic [SIZE_BITS-1:0] chunk_left;
   logic                 line_has_text;
   logic                 cr_pending;
   logic [1:0]           skip_left;
   logic [1:0]           held_error;

   decoded_rsp_type expected_rsps[$];
   int              errors;
   int              checked;
   int              payloads;
   int              completes;
   int              error_hits;

   function automatic int hex_digit(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      return -1;
   endfunction

   function automatic logic is_blank(logic [7:0] c);
      return c == 8'h20 || c == 8'h09 || c == chbd_pkg::CHAR_LF || c == 8'h0B ||
             c == 8'h0C || c == chbd_pkg::CHAR_CR;
   endfunction

   // A full clear also drops the skip count and the sticky error.
   task automatic clear_decoder(input bit full);
      dec_phase     = chbd_pkg::PH_LEAD;
      chunk_left    = '0;
      line_has_text = 1'b0;
      cr_pending    = 1'b0;
      if (full) begin
         skip_left  = '0;
         held_error = chbd_pkg::ERR_NONE;
      end
   endtask

   // One character of size line content, never part of the CR LF ending.
   task automatic take_line_char(input logic [7:0] c);
      int h;
      h = hex_digit(c);
      line_has_text = 1'b1;
      if (dec_phase == chbd_pkg::PH_REST) return;
      if (h >= 0) begin
         // Shifting in another digit would exceed the counter width.
         if (chunk_left[SIZE_BITS-1 -: 4] != 4'd0) begin
            held_error = chbd_pkg::ERR_OVERFLOW;
            dec_phase  = chbd_pkg::PH_ERROR;
         end else begin
            chunk_left = {chunk_left[SIZE_BITS-5:0], h[3:0]};
            dec_phase  = chbd_pkg::PH_DIGITS;
         end
      end else if (!(dec_phase == chbd_pkg::PH_LEAD && is_blank(c))) begin
         dec_phase = chbd_pkg::PH_REST;
      end
   endtask

   task automatic predict_response(input logic [7:0] c, input logic sob,
                                   output decoded_rsp_type r);
      r = '0;
      if (sob) clear_decoder(1'b1);
      case (dec_phase)
         chbd_pkg::PH_LEAD, chbd_pkg::PH_DIGITS, chbd_pkg::PH_REST: begin
            if (cr_pending && c == chbd_pkg::CHAR_LF) begin
               cr_pending = 1'b0;
               if (!line_has_text) begin
                  held_error = chbd_pkg::ERR_EMPTY;
                  dec_phase  = chbd_pkg::PH_ERROR;
               end else if (chunk_left == '0) begin
                  dec_phase = chbd_pkg::PH_DONE;
               end else begin
                  dec_phase = chbd_pkg::PH_DATA;
               end
            end else begin
               // A CR that was not followed by LF is ordinary line content.
               if (cr_pending) begin
                  cr_pending = 1'b0;
                  take_line_char(chbd_pkg::CHAR_CR);
               end
               if (dec_phase != chbd_pkg::PH_ERROR) begin
                  if (c == chbd_pkg::CHAR_CR) cr_pending = 1'b1;
                  else take_line_char(c);
               end
            end
         end
         chbd_pkg::PH_DATA: begin
            r.payload_valid = 1'b1;
            r.payload_byte  = c;
            chunk_left      = chunk_left - SIZE_BITS'(1);
            if (chunk_left == '0) begin
               dec_phase = chbd_pkg::PH_SKIP;
               skip_left = 2'd2;
            end
         end
         chbd_pkg::PH_SKIP: begin
            skip_left = skip_left - 2'd1;
            if (skip_left == 2'd0) clear_decoder(1'b0);
         end
         default: ;
      endcase
      r.body_complete = (dec_phase == chbd_pkg::PH_DONE);
      r.error_code    = held_error;
   endtask

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("response %0d %s: got 0x%0h, expected 0x%0h",
                                   checked, name, got, want));
   endtask

   always @(posedge clock) begin : monitor
      decoded_rsp_type want;
      if (reset) begin
         clear_decoder(1'b1);
         expected_rsps.delete();
         errors     = 0;
         checked    = 0;
         payloads   = 0;
         completes  = 0;
         error_hits = 0;
      end else begin
         // Responses are matched first so that a request accepted on the same
         // edge cannot hide a response that nothing asked for.
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch($sformatf("response %0d arrived with no request outstanding",
                                         checked));
            end else begin
               want = expected_rsps.pop_front();
               check_field("payload_valid", 8'(rsp_payload_valid), 8'(want.payload_valid));
               check_field("payload_byte", rsp_payload_byte, want.payload_byte);
               check_field("body_complete", 8'(rsp_body_complete), 8'(want.body_complete));
               check_field("error_code", 8'(rsp_error_code), 8'(want.error_code));
            end
            checked++;
            if (rsp_payload_valid) payloads++;
            if (rsp_body_complete) completes++;
            if (rsp_error_code != chbd_pkg::ERR_NONE) error_hits++;
         end
         if (req_valid && !req_stall) begin
            predict_response(req_body_byte, req_start_of_body, want);
            expected_rsps.insert(expected_rsps.size(), want);
         end
      end
      fail_count    <= errors;
      pending_rsps  <= expected_rsps.size();
      checked_rsps  <= checked;
      payload_rsps  <= payloads;
      complete_rsps <= completes;
      error_rsps    <= error_hits;
   end

endmodule

// ===== tb/tb_http_chunked_body_decoder_top.sv =====
// ============================================================================
// tb_http_chunked_body_decoder_top
// Byte stream testbench for the chunked HTTP body decoder. A short directed
// set of bodies is followed by random bodies, mostly well formed with random
// sizes, blanks, extensions and payload, the rest truncated or malformed.
// A checker module beside the block predicts and compares every response.
// ============================================================================

module tb_http_chunked_body_decoder_top;

   localparam int SIZE_BITS       = chbd_pkg::SIZE_BITS_DEFAULT;
   // Roughly how many request transactions each random phase contributes.
   localparam int ITEMS_PER_PHASE = 170;
   // Receiver hold-off used to fill the queue and back-pressure the sender.
   localparam int HOLD_OFF_CYCLES = 150;
   // Extra cycles after the last response.
   localparam int DRAIN_CYCLES    = 10;

   logic       clock;
   logic       reset             = 1'b1;
   logic       req_valid         = 1'b0;
   logic       req_stall;
   logic [7:0] req_body_byte     = 8'h00;
   logic       req_start_of_body = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall         = 1'b0;
   logic       rsp_payload_valid;
   logic [7:0] rsp_payload_byte;
   logic       rsp_body_complete;
   logic [1:0] rsp_error_code;

   int fail_count;
   int pending_rsps;
   int checked_rsps;
   int payload_rsps;
   int complete_rsps;
   int error_rsps;

   // Idle percentages for each side, changed from phase to phase.
   int send_idle_pct = 0;
   int rcv_idle_pct  = 0;
   // When nonzero, the receiver stalls for this many more cycles.
   int hold_off_left = 0;

   // Bytes waiting to be offered, with their start-of-body flags.
   logic [7:0] stream_bytes[$];
   logic       stream_sob[$];
   // Set when a new body begins; the next pushed byte then carries the flag.
   bit         body_opening = 1'b0;
   // Counts the bytes that the decoder actually acts on.
   int         queued_items = 0;

   logic [7:0] blank_chars[5] = '{8'h20, 8'h09, chbd_pkg::CHAR_LF, 8'h0B, 8'h0C};

   http_chunked_body_decoder_top #(
      .SIZE_BITS(SIZE_BITS)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_body_byte    (req_body_byte),
      .req_start_of_body(req_start_of_body),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload_valid(rsp_payload_valid),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_body_complete(rsp_body_complete),
      .rsp_error_code   (rsp_error_code)
   );

   http_chunked_body_decoder_checker #(
      .SIZE_BITS(SIZE_BITS)
   ) checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_body_byte    (req_body_byte),
      .req_start_of_body(req_start_of_body),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload_valid(rsp_payload_valid),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_body_complete(rsp_body_complete),
      .rsp_error_code   (rsp_error_code),
      .fail_count       (fail_count),
      .pending_rsps     (pending_rsps),
      .checked_rsps     (checked_rsps),
      .payload_rsps     (payload_rsps),
      .complete_rsps    (complete_rsps),
      .error_rsps       (error_rsps)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The run is bounded by a fixed time far beyond the slowest legal run.
   initial begin
      #2000000;
      $display("Timeout: responses still outstanding after the time limit.");
      $display("** http_chunked_body_decoder_top: FAILED **");
      $finish;
   end

   // Receiver side. Either a counted hold-off is in progress, or the stall is
   // drawn fresh every cycle from the current idle percentage.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_left > 0) begin
            rsp_stall <= 1'b1;
            hold_off_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
         end
      end
   end

   // Queues one byte. Bytes that the decoder ignores, after a completed or
   // failed body, are queued with counted cleared.
   task automatic push_byte(input logic [7:0] b, input bit counted = 1'b1);
      stream_bytes.insert(stream_bytes.size(), b);
      stream_sob.insert(stream_sob.size(), body_opening);
      body_opening = 1'b0;
      if (counted) queued_items++;
   endtask

   function automatic logic [7:0] hex_char(input int v, input bit upper);
      if (v < 10) return 8'(8'h30 + v);
      return upper ? 8'(8'h41 + v - 10) : 8'(8'h61 + v - 10);
   endfunction

   // A size line: optional leading blanks, the hex size in random case with
   // an occasional leading zero, an optional extension or stray CR, then CR LF.
   task automatic push_size_line(input int chunk_len);
      int digits;
      digits = 1;
      while (digits < 8 && (chunk_len >> (4 * digits)) != 0) digits++;
      if ($urandom_range(3) == 0)
         repeat ($urandom_range(1, 2)) push_byte(blank_chars[$urandom_range(4)]);
      if ($urandom_range(5) == 0) push_byte("0");
      for (int i = digits - 1; i >= 0; i--)
         push_byte(hex_char((chunk_len >> (4 * i)) & 15, 1'($urandom_range(1))));
      case ($urandom_range(7))
         0, 1: begin
            push_byte(";");
            repeat ($urandom_range(3)) push_byte(8'($urandom_range(8'h20, 8'h7E)));
         end
         2: begin
            // A CR that is not followed by LF ends the number and is then
            // just part of the rest of the line.
            push_byte(chbd_pkg::CHAR_CR);
            push_byte("x");
         end
         default: ;
      endcase
      push_byte(chbd_pkg::CHAR_CR);
      push_byte(chbd_pkg::CHAR_LF);
   endtask

   // One chunk with its size line, random payload and the two skipped bytes.
   task automatic push_chunk();
      int chunk_len;
      chunk_len = ($urandom_range(9) == 0) ? $urandom_range(16, 80) : $urandom_range(1, 8);
      push_size_line(chunk_len);
      repeat (chunk_len) push_byte(8'($urandom_range(255)));
      if ($urandom_range(4) != 0) begin
         push_byte(chbd_pkg::CHAR_CR);
         push_byte(chbd_pkg::CHAR_LF);
      end else begin
         push_byte(8'($urandom_range(255)));
         push_byte(8'($urandom_range(255)));
      end
   endtask

   // Builds one random body. Most are well formed; the rest cover the
   // malformed and interrupted cases.
   task automatic make_body();
      logic [7:0] junk;
      logic [7:0] prev;
      int         chunk_len;
      body_opening = 1'b1;
      if ($urandom_range(99) < 75) begin
         repeat ($urandom_range(3)) push_chunk();
         push_size_line(0);
         repeat ($urandom_range(1)) push_byte(8'($urandom_range(255)), 1'b0);
      end else begin
         case ($urandom_range(4))
            0: begin
               // Empty size line, possibly after a good chunk.
               if ($urandom_range(1)) push_chunk();
               push_byte(chbd_pkg::CHAR_CR);
               push_byte(chbd_pkg::CHAR_LF);
               push_byte(8'($urandom_range(255)), 1'b0);
            end
            1: begin
               // One digit more than the counter holds, the first nonzero.
               push_byte(hex_char($urandom_range(1, 15), 1'($urandom_range(1))));
               repeat (SIZE_BITS / 4)
                  push_byte(hex_char($urandom_range(15), 1'($urandom_range(1))));
               repeat ($urandom_range(2)) push_byte(8'($urandom_range(255)), 1'b0);
            end
            2: begin
               // Stray CR and bare LF content on a line without digits.
               prev = 8'h00;
               repeat ($urandom_range(1, 4)) begin
                  case ($urandom_range(3))
                     0: junk = chbd_pkg::CHAR_CR;
                     1: junk = chbd_pkg::CHAR_LF;
                     2: junk = 8'h20;
                     default: junk = "x";
                  endcase
                  if (prev == chbd_pkg::CHAR_CR && junk == chbd_pkg::CHAR_LF) junk = "x";
                  push_byte(junk);
                  prev = junk;
               end
               if (prev == chbd_pkg::CHAR_CR) push_byte("x");
               push_byte(chbd_pkg::CHAR_CR);
               push_byte(chbd_pkg::CHAR_LF);
            end
            3: begin
               repeat ($urandom_range(3, 12)) push_byte(8'($urandom_range(255)));
            end
            default: begin
               // Body cut short in its payload; the next body restarts it.
               chunk_len = $urandom_range(2, 8);
               push_size_line(chunk_len);
               repeat (chunk_len / 2) push_byte(8'($urandom_range(255)));
            end
         endcase
      end
   endtask

   // Offers every queued byte in order. Valid is left high after the last
   // acceptance so that back-to-back transactions need no extra step.
   task automatic send_stream();
      while (stream_bytes.size() != 0) begin
         while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
         req_valid         <= 1'b1;
         req_body_byte     <= stream_bytes.pop_front();
         req_start_of_body <= stream_sob.pop_front();
         do @(posedge clock); while (req_stall);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, under the first idling pattern.
      send_idle_pct = 11;
      rcv_idle_pct  = 71;

      // Leading blank, a two-byte chunk with both extreme payload values,
      // then the zero chunk and one byte after completion.
      body_opening = 1'b1;
      push_byte(8'h20);
      push_byte("2");
      push_byte(chbd_pkg::CHAR_CR);
      push_byte(chbd_pkg::CHAR_LF);
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(chbd_pkg::CHAR_CR);
      push_byte(chbd_pkg::CHAR_LF);
      push_byte("0");
      push_byte(chbd_pkg::CHAR_CR);
      push_byte(chbd_pkg::CHAR_LF);
      push_byte("z", 1'b0);

      // An empty size line raises the error, and the next byte is ignored.
      body_opening = 1'b1;
      push_byte(chbd_pkg::CHAR_CR);
      push_byte(chbd_pkg::CHAR_LF);
      push_byte("5", 1'b0);

      // A bare LF and a stray CR make a line with no digits: size zero.
      body_opening = 1'b1;
      push_byte(chbd_pkg::CHAR_LF);
      push_byte(chbd_pkg::CHAR_CR);
      push_byte(chbd_pkg::CHAR_CR);
      push_byte(chbd_pkg::CHAR_LF);

      // All-ones digits until the counter overflows.
      body_opening = 1'b1;
      repeat (SIZE_BITS / 4 + 1) push_byte("F");
      send_stream();

      // Random part in three idling phases. The last one also holds the
      // receiver off long enough for the queue to fill while the sender keeps
      // offering, so the request stall is exercised.
      for (int phase_idx = 0; phase_idx < 3; phase_idx++) begin
         int target;
         case (phase_idx)
            0: begin
               send_idle_pct = 11;
               rcv_idle_pct  = 71;
            end
            1: begin
               send_idle_pct = 71;
               rcv_idle_pct  = 11;
            end
            default: begin
               send_idle_pct = 0;
               rcv_idle_pct  = 0;
               hold_off_left = HOLD_OFF_CYCLES;
            end
         endcase
         target = queued_items + ITEMS_PER_PHASE;
         while (queued_items < target) begin
            make_body();
            send_stream();
         end
      end
      req_valid <= 1'b0;

      // Let every outstanding response arrive, then a few quiet cycles.
      while (pending_rsps != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d request bytes and %0d checked responses.",
               queued_items, checked_rsps);
      $display("Responses carrying payload: %0d, flagged complete: %0d, with an error: %0d.",
               payload_rsps, complete_rsps, error_rsps);
      if (fail_count == 0 && pending_rsps == 0) begin
         $display("** http_chunked_body_decoder_top: PASSED **");
      end else begin
         $display("** http_chunked_body_decoder_top: FAILED **");
      end
      $finish;
   end

endmodule
